[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication check, clocked on clk_i, disabled in reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pvd_pkg.sv]
// ----------------------------------------------------------------------------
// pvd_pkg
// Types, constants and trellis tables of the punctured Viterbi decoder.
// ----------------------------------------------------------------------------
package pvd_pkg;

  localparam int unsigned TbLen     = 1024;
  localparam int unsigned NumStates = 64;
  localparam int unsigned StW       = 6;
  localparam int unsigned PosW      = $clog2(TbLen);
  localparam int unsigned CntW      = $clog2(TbLen + 1);
  localparam int unsigned NumWords  = (TbLen + 63) / 64;
  localparam int unsigned WordW     = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned MetW      = 13;
  localparam logic [MetW-1:0] MetUnreach = 13'd8191;
  localparam logic [MetW-1:0] MetSat     = 13'd8190;

  // Rate codes
  localparam logic [1:0] RateHalf   = 2'd0;
  localparam logic [1:0] RateTwo3rd = 2'd1;

  typedef struct packed {
    logic [1:0] code_pair;
    logic [1:0] code_rate;
    logic       first_step;
    logic       tail_step;
    logic       last_step;
  } in_item_t;

  typedef struct packed {
    logic [63:0] bits;
    logic [6:0]  bit_count;
    logic        last_word;
    logic        packet_end;
    logic        decode_failed;
  } out_item_t;

  // Classified step passed from front to back.
  typedef struct packed {
    logic [1:0] code_pair;
    logic       keep0;
    logic       keep1;
    logic       first_step;
    logic       tail_step;
    logic       last_step;
  } step_t;

  // Encoder output for (previous state, input bit): {bit1, bit0}
  function automatic logic [1:0] branch_code(input logic [StW-1:0] st, input logic b);
    logic [1:0] r;
    // code for input bit 0 is one of 0..3; input bit 1 gives its complement
    case (st)
      6'd0, 6'd6, 6'd8, 6'd14, 6'd19, 6'd21, 6'd27, 6'd29, 6'd34, 6'd36,
      6'd42, 6'd44, 6'd49, 6'd55, 6'd57, 6'd63: r = 2'd0;
      6'd1, 6'd7, 6'd9, 6'd15, 6'd18, 6'd20, 6'd26, 6'd28, 6'd35, 6'd37,
      6'd43, 6'd45, 6'd48, 6'd54, 6'd56, 6'd62: r = 2'd2;
      6'd2, 6'd4, 6'd10, 6'd12, 6'd17, 6'd23, 6'd25, 6'd31, 6'd32, 6'd38,
      6'd40, 6'd46, 6'd51, 6'd53, 6'd59, 6'd61: r = 2'd3;
      default: r = 2'd1;
    endcase
    return b ? ~r : r;
  endfunction

  function automatic logic [1:0] branch_metric(input logic [1:0] pair, input logic [1:0] exp,
                                               input logic k0, input logic k1);
    logic [1:0] d;
    d = pair ^ exp;
    return {1'b0, d[0] & k0} + {1'b0, d[1] & k1};
  endfunction

  function automatic logic [MetW-1:0] metric_add(input logic [MetW-1:0] m,
                                                 input logic [1:0] bm);
    logic [MetW:0] s;
    s = {1'b0, m} + {{(MetW-1){1'b0}}, bm};
    if (m == MetUnreach) return MetUnreach;
    return (s > {1'b0, MetSat}) ? MetSat : s[MetW-1:0];
  endfunction

endpackage

[rtl/core/pvd_stream_if.sv]
// ----------------------------------------------------------------------------
// pvd_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface pvd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/pvd_front.sv]
// ----------------------------------------------------------------------------
// pvd_front
// Accepts steps, tracks the puncture phase and resolves the keep mask,
// then pushes classified steps into a small queue for the back end.
// ----------------------------------------------------------------------------
module pvd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pvd_pkg::in_item_t   in_data_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output pvd_pkg::step_t      q_data_o
);
  import pvd_pkg::*;

  localparam int unsigned QDepth = 4;

  step_t      fifo_q [QDepth];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic [3:0] phase_q, phase_d;
  logic [3:0] phase_use;
  logic [3:0] period;
  logic [4:0] kidx;
  logic [17:0] keep34;
  logic [11:0] keep23;
  logic        k0, k1;
  logic        push, pop;
  step_t       step;

  assign keep34 = 18'b100111100111100111;
  assign keep23 = 12'b011101110111;

  assign in_ready_o = (count_q != 3'(QDepth));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && (count_q != 3'd0);
  assign q_valid_o  = (count_q != 3'd0);
  assign q_data_o   = fifo_q[rd_ptr_q];

  // Puncture pattern lookup
  always_comb begin
    phase_use = in_data_i.first_step ? 4'd0 : phase_q;
    case (in_data_i.code_rate)
      RateHalf:   period = 4'd1;
      RateTwo3rd: period = 4'd6;
      default:    period = 4'd9;
    endcase
    if (phase_use >= period) phase_use = 4'd0;
    kidx = {phase_use, 1'b0};
    case (in_data_i.code_rate)
      RateHalf:   begin k0 = 1'b1; k1 = 1'b1; end
      RateTwo3rd: begin k0 = keep23[kidx[3:0]]; k1 = keep23[kidx[3:0] + 4'd1]; end
      default:    begin k0 = keep34[kidx]; k1 = keep34[kidx + 5'd1]; end
    endcase
    phase_d = (phase_use + 4'd1 == period) ? 4'd0 : phase_use + 4'd1;
    if (in_data_i.last_step) phase_d = 4'd0;
    step = '{code_pair: in_data_i.code_pair, keep0: k0, keep1: k1,
             first_step: in_data_i.first_step, tail_step: in_data_i.tail_step,
             last_step: in_data_i.last_step};
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      phase_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
        phase_q  <= phase_d;
      end
      if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + 3'(push) - 3'(pop);
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_overflow, count_q == 3'(QDepth), !push, "push into full queue")
  `ASSERT_IMPL(a_count_range, 1'b1, count_q <= 3'(QDepth), "queue count out of range")
  `ASSERT_IMPL(a_phase_range, 1'b1, phase_q < 4'd9, "puncture phase out of range")
endmodule

[rtl/core/pvd_back.sv]
// ----------------------------------------------------------------------------
// pvd_back
// ACS over 64 states per step, survivor memory, minimum search and
// serial traceback that assembles output words.
// ----------------------------------------------------------------------------
module pvd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  pvd_pkg::step_t      q_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pvd_pkg::out_item_t  out_data_o
);
  import pvd_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMin  = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StTb   = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;
  localparam logic [2:0] StFail = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [MetW-1:0] pm_q [NumStates];
  logic [MetW-1:0] nm   [NumStates];
  logic [63:0]     dec;
  logic [63:0]     surv_mem [TbLen];
  logic [63:0]     rd_data_q;
  logic [PosW-1:0] rd_addr;
  logic [StW-1:0]  start_q;
  logic [PosW-1:0] sib_q;
  logic [StW-1:0]  cur_q;
  logic [CntW-1:0] tb_n_q;
  logic [CntW-1:0] t_q;
  logic [StW-1:0]  scan_q;
  logic [StW-1:0]  best_q;
  logic [MetW-1:0] bestm_q;
  logic [MetW-1:0] min_last;
  logic            pend_q, tail_flush_q;
  logic [63:0]     words_q [NumWords];
  logic [WordW:0]  w_q;
  logic [WordW:0]  nwords;
  logic            last_w;
  out_item_t       out_q;
  logic            out_v_q;
  logic            emit_fire;
  logic            do_step;
  logic [PosW:0]   s_next;
  logic [PosW-1:0] pos;
  logic [StW-1:0]  nxt_cur;

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign do_step = (state_q == StIdle) && q_valid_i;
  assign q_pop_o = do_step;
  assign s_next  = {1'b0, (q_data_i.first_step ? '0 : sib_q)} + 1'b1;
  assign pos     = PosW'(t_q - 1'b1);
  assign nwords  = (WordW+1)'((tb_n_q + CntW'(63)) >> 6);
  assign nxt_cur = {rd_data_q[cur_q], cur_q[StW-1:1]};
  assign min_last  = (pm_q[scan_q] < bestm_q) ? pm_q[scan_q] : bestm_q;
  assign emit_fire = (state_q == StEmit || state_q == StFail) && (!out_v_q || out_ready_i);
  assign last_w    = (w_q + 1'b1 == nwords);

  // Add-compare-select, all states in parallel
  always_comb begin
    logic [StW-1:0] st;
    logic [1:0] b0, b1;
    logic [MetW-1:0] c0, c1;
    logic restart;
    st = q_data_i.first_step ? '0 : start_q;
    restart = q_data_i.first_step || (sib_q == '0);
    dec = '0;
    for (int i = 0; i < NumStates; i++) begin
      b0 = branch_metric(q_data_i.code_pair, branch_code(StW'(i >> 1), i[0]),
                         q_data_i.keep0, q_data_i.keep1);
      b1 = branch_metric(q_data_i.code_pair, branch_code(StW'((i >> 1) | 32), i[0]),
                         q_data_i.keep0, q_data_i.keep1);
      c0 = metric_add(pm_q[i >> 1], b0);
      c1 = metric_add(pm_q[(i >> 1) | 32], b1);
      if (restart) begin
        nm[i] = MetUnreach;
      end else if (q_data_i.tail_step && i[0]) begin
        nm[i] = MetUnreach;
      end else if (c0 < c1) begin
        nm[i] = c0;
      end else begin
        nm[i] = c1;
        dec[i] = 1'b1;
      end
    end
    if (restart) begin
      dec = st[StW-1] ? '1 : '0;
      nm[{st[StW-2:0], 1'b0}] = {11'd0, branch_metric(q_data_i.code_pair,
                                 branch_code(st, 1'b0), q_data_i.keep0, q_data_i.keep1)};
      nm[{st[StW-2:0], 1'b1}] = q_data_i.tail_step ? MetUnreach :
        {11'd0, branch_metric(q_data_i.code_pair, branch_code(st, 1'b1),
                              q_data_i.keep0, q_data_i.keep1)};
    end
  end

  // Survivor memory, one port each way
  assign rd_addr = (state_q == StRd || state_q == StTb) ? pos : '0;
  always_ff @(posedge clk_i) begin
    if (do_step) surv_mem[q_data_i.first_step ? '0 : sib_q] <= dec;
    rd_data_q <= surv_mem[rd_addr];
  end

  // Path metrics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStates; i++) pm_q[i] <= MetUnreach;
    end else if (do_step) begin
      for (int i = 0; i < NumStates; i++) pm_q[i] <= nm[i];
    end
  end

  // Control sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (do_step && (s_next == (PosW+1)'(TbLen) || q_data_i.last_step)) begin
                state_d = StMin;
              end
      StMin:  if (scan_q == StW'(NumStates - 1)) begin
                state_d = (!tail_flush_q && min_last == MetUnreach) ? StFail : StRd;
              end
      StRd:   state_d = StTb;
      StTb:   if (t_q == CntW'(1)) state_d = StEmit;
              else state_d = StRd;
      StEmit: if (emit_fire && last_w) state_d = StIdle;
      StFail: if (emit_fire) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    // Traceback word assembly; words are cleared at the start of the minimum search
    if (state_q == StTb) begin
      words_q[pos[PosW-1:6]][pos[5:0]] <= cur_q[0];
    end else if (state_q == StMin && scan_q == '0) begin
      for (int w = 0; w < NumWords; w++) words_q[w] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      start_q      <= '0;
      sib_q        <= '0;
      cur_q        <= '0;
      tb_n_q       <= '0;
      t_q          <= '0;
      scan_q       <= '0;
      best_q       <= '0;
      bestm_q      <= MetUnreach;
      pend_q       <= 1'b0;
      tail_flush_q <= 1'b0;
      w_q          <= '0;
      out_v_q      <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q <= state_d;
      if (emit_fire) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (do_step) begin
            pend_q <= q_data_i.last_step;
            if (s_next == (PosW+1)'(TbLen)) begin
              if (q_data_i.first_step) start_q <= '0;
              sib_q <= '0;
              tail_flush_q <= 1'b0;
              scan_q <= '0;
            end else if (q_data_i.last_step) begin
              sib_q <= '0;
              start_q <= '0;
              tb_n_q <= CntW'(s_next);
              t_q <= CntW'(s_next);
              cur_q <= '0;
              tail_flush_q <= 1'b1;
              scan_q <= '0;
              best_q <= '0;
            end else begin
              if (q_data_i.first_step) start_q <= '0;
              sib_q <= PosW'(s_next);
            end
          end
        end
        StMin: begin
          // Sequential minimum search (skipped in effect for tail flush)
          scan_q <= scan_q + 1'b1;
          if (!tail_flush_q) begin
            if (scan_q == '0 || pm_q[scan_q] < bestm_q) begin
              bestm_q <= pm_q[scan_q];
              best_q  <= scan_q;
            end
            if (scan_q == StW'(NumStates - 1) && min_last != MetUnreach) begin
              cur_q  <= (pm_q[scan_q] < bestm_q) ? scan_q : best_q;
              tb_n_q <= CntW'(TbLen);
              t_q    <= CntW'(TbLen);
            end
          end
        end
        StRd: ;
        StTb: begin
          t_q <= t_q - 1'b1;
          if (pos != '0) cur_q <= nxt_cur;
          if (t_q == CntW'(1)) w_q <= '0;
        end
        StEmit: begin
          if (emit_fire) begin
            out_q.bits <= words_q[w_q[WordW-1:0]];
            out_q.bit_count <= (tb_n_q - CntW'({w_q, 6'd0}) > CntW'(64)) ? 7'd64 :
                               7'(tb_n_q - CntW'({w_q, 6'd0}));
            out_q.last_word <= last_w;
            out_q.packet_end <= pend_q;
            out_q.decode_failed <= 1'b0;
            w_q <= w_q + 1'b1;
            if (last_w) start_q <= (tail_flush_q || pend_q) ? '0 : best_q;
          end
        end
        StFail: begin
          if (emit_fire) begin
            out_q <= '{bits: '0, bit_count: 7'd0, last_word: 1'b1,
                       packet_end: pend_q, decode_failed: 1'b1};
            start_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_pop_idle, q_pop_o, state_q == StIdle, "pop outside idle")
  `ASSERT_NEXT(a_out_hold, out_v_q && !out_ready_i, out_v_q && $stable(out_q), "output hold")
  `ASSERT_NEXT(a_fail_word, state_q == StFail && (!out_v_q || out_ready_i),
               out_v_q && out_q.decode_failed, "failure word missing")
endmodule

[rtl/core/punctured_viterbi_decoder_k7.sv]
// Flow: a step enters the 4-entry queue when accepted and updates the path metrics
// when the back end pops it; a block or packet end adds a minimum search over the 64
// states and StRd/StTb per traced step, then one word per cycle while out_if is ready.
// Throughput: one step per cycle between flushes; input stalls once the queue fills.
// Reset: metrics unreachable, start state, block position and phase zero.
// ----------------------------------------------------------------------------
// punctured_viterbi_decoder_k7
// Top level: puncture front end, step queue, ACS and traceback back end.
// ----------------------------------------------------------------------------
module punctured_viterbi_decoder_k7 (
  input  logic clk_i,
  input  logic rst_ni,
  pvd_stream_if.sink   in_if,
  pvd_stream_if.source out_if
);
  import pvd_pkg::*;

  logic  q_valid, q_pop;
  step_t q_data;

  pvd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_data_i  (in_if.data),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_data_o   (q_data)
  );

  pvd_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );
endmodule

[test/tb_pvd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pvd_checker
// Watches both channels of the decoder. Every accepted step goes through a
// local trellis model, and each accepted word is compared field by field
// with the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_pvd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  pvd_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  pvd_pkg::out_item_t out_data_i,
  output int                 err_cnt_o,
  output int                 pending_o
);
  import pvd_pkg::*;

  localparam int BlkLen = TbLen;
  localparam int Unreach = int'(MetUnreach);
  localparam int Sat = int'(MetSat);

  // Encoder output for input bit 0 per state; bit 1 gives the complement.
  localparam logic [1:0] Code0 [64] = '{
    2'd0, 2'd2, 2'd3, 2'd1, 2'd3, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2,
    2'd3, 2'd1, 2'd3, 2'd1, 2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd0,
    2'd2, 2'd0, 2'd1, 2'd3, 2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd0,
    2'd1, 2'd3, 2'd3, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd3, 2'd1,
    2'd3, 2'd1, 2'd0, 2'd2, 2'd0, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0,
    2'd1, 2'd3, 2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd3,
    2'd1, 2'd3, 2'd2, 2'd0
  };
  localparam logic [17:0] Keep34 = 18'b100111100111100111; // bit i = slot i
  localparam logic [11:0] Keep23 = 12'b011101110111;

  int          metric [64];
  logic [63:0] surv [BlkLen];
  int          start_st;
  int          blk_pos;
  int          phase;
  out_item_t   word_q[$];
  int          errors;

  assign err_cnt_o = errors;
  assign pending_o = word_q.size();

  function automatic int branch_dist(logic [1:0] pair, logic [1:0] code,
                                     logic k0, logic k1);
    logic [1:0] d;
    d = pair ^ code;
    return int'(d[0] & k0) + int'(d[1] & k1);
  endfunction

  function automatic int grow(int m, int bm);
    if (m >= Unreach) return Unreach;
    return (m + bm > Sat) ? Sat : m + bm;
  endfunction

  // Trace n steps back from state fin and queue the decided words.
  function automatic void trace_words(int n, int fin, logic pend);
    out_item_t w [NumWords];
    int        nw;
    int        cur;
    int        pos;
    nw  = (n + 63) / 64;
    cur = fin;
    for (int k = 0; k < nw; k++) begin
      w[k].bits          = '0;
      w[k].bit_count     = 7'((n - 64 * k > 64) ? 64 : n - 64 * k);
      w[k].last_word     = (k + 1 == nw);
      w[k].packet_end    = pend;
      w[k].decode_failed = 1'b0;
    end
    for (int t = n; t > 0; t--) begin
      pos = t - 1;
      w[pos / 64].bits[pos % 64] = cur[0];
      if (pos > 0) cur = ((cur >> 1) | (int'(surv[pos][cur]) << 5)) & 63;
    end
    for (int k = 0; k < nw; k++) word_q.push_back(w[k]);
  endfunction

  // One trellis step of the decoder.
  function automatic void decode_step(in_item_t it);
    int          period;
    logic        k0, k1;
    int          s, a, c0, c1, p0, p1, best, bmin;
    int          nm [64];
    logic [63:0] dec;
    out_item_t   fw;
    dec = '0;
    if (it.first_step) begin
      start_st = 0;
      blk_pos  = 0;
      phase    = 0;
    end
    period = (it.code_rate == RateHalf) ? 1 : (it.code_rate == RateTwo3rd) ? 6 : 9;
    if (phase >= period) phase = 0;
    if (it.code_rate == RateHalf) begin
      k0 = 1'b1;
      k1 = 1'b1;
    end else if (it.code_rate == RateTwo3rd) begin
      k0 = Keep23[2 * phase];
      k1 = Keep23[2 * phase + 1];
    end else begin
      k0 = Keep34[2 * phase];
      k1 = Keep34[2 * phase + 1];
    end
    s = (blk_pos >= BlkLen) ? 0 : blk_pos;
    if (s == 0) begin
      // restart: only the two successors of the start state are live
      a = (start_st << 1) & 63;
      for (int i = 0; i < 64; i++) nm[i] = Unreach;
      nm[a]     = branch_dist(it.code_pair, Code0[start_st], k0, k1);
      nm[a | 1] = it.tail_step ? Unreach :
                  branch_dist(it.code_pair, ~Code0[start_st], k0, k1);
      dec = (start_st >> 5) ? '1 : '0;
    end else begin
      for (int i = 0; i < 64; i++) begin
        p0 = i >> 1;
        p1 = p0 | 32;
        if (it.tail_step && i[0]) begin
          nm[i] = Unreach;
        end else begin
          c0 = grow(metric[p0], branch_dist(it.code_pair,
                    i[0] ? ~Code0[p0] : Code0[p0], k0, k1));
          c1 = grow(metric[p1], branch_dist(it.code_pair,
                    i[0] ? ~Code0[p1] : Code0[p1], k0, k1));
          // ties go to the predecessor with top bit set
          if (c0 < c1) begin
            nm[i] = c0;
          end else begin
            nm[i]  = c1;
            dec[i] = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < 64; i++) metric[i] = nm[i];
    surv[s] = dec;
    phase = (phase + 1) % period;
    s++;
    if (s >= BlkLen) begin
      best = 0;
      bmin = metric[0];
      for (int i = 1; i < 64; i++) begin
        if (metric[i] < bmin) begin
          bmin = metric[i];
          best = i;
        end
      end
      if (bmin >= Unreach) begin
        fw.bits          = '0;
        fw.bit_count     = '0;
        fw.last_word     = 1'b1;
        fw.packet_end    = it.last_step;
        fw.decode_failed = 1'b1;
        word_q.push_back(fw);
        start_st = 0;
      end else begin
        trace_words(BlkLen, best, it.last_step);
        start_st = best;
      end
      blk_pos = 0;
    end else begin
      blk_pos = s;
    end
    if (it.last_step) begin
      if (blk_pos > 0) trace_words(blk_pos, 0, 1'b1);
      start_st = 0;
      blk_pos  = 0;
      phase    = 0;
    end
  endfunction

  initial begin
    for (int i = 0; i < 64; i++) metric[i] = Unreach;
    for (int i = 0; i < BlkLen; i++) surv[i] = '0;
    start_st = 0;
    blk_pos  = 0;
    phase    = 0;
    errors   = 0;
  end

  // Compare output beats, then feed accepted input beats to the model.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (word_q.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, out_data_i);
        errors++;
      end else begin
        e = word_q.pop_front();
        if (out_data_i.bits !== e.bits) begin
          $display("%0t: bits expected %h actual %h", $time, e.bits, out_data_i.bits);
          errors++;
        end
        if (out_data_i.bit_count !== e.bit_count) begin
          $display("%0t: bit_count expected %0d actual %0d", $time, e.bit_count,
                   out_data_i.bit_count);
          errors++;
        end
        if (out_data_i.last_word !== e.last_word) begin
          $display("%0t: last_word expected %b actual %b", $time, e.last_word,
                   out_data_i.last_word);
          errors++;
        end
        if (out_data_i.packet_end !== e.packet_end) begin
          $display("%0t: packet_end expected %b actual %b", $time, e.packet_end,
                   out_data_i.packet_end);
          errors++;
        end
        if (out_data_i.decode_failed !== e.decode_failed) begin
          $display("%0t: decode_failed expected %b actual %b", $time, e.decode_failed,
                   out_data_i.decode_failed);
          errors++;
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_i) decode_step(in_data_i);
  end

endmodule

[test/tb_punctured_viterbi_decoder_k7.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_punctured_viterbi_decoder_k7
// Drives packets of trellis steps into the decoder with random gaps and
// receiver stalls; the checker predicts and compares the decoded words.
// ----------------------------------------------------------------------------
module tb_punctured_viterbi_decoder_k7;
  import pvd_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   err_cnt;
  int   pending;
  logic hold_off;
  logic burst;

  pvd_stream_if #(.T(in_item_t))  in_ch ();
  pvd_stream_if #(.T(out_item_t)) out_ch ();

  punctured_viterbi_decoder_k7 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  tb_pvd_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones; none while in a burst stretch.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (burst || r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else begin
        out_ch.ready <= (gap_len() == 0);
        @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(in_item_t it);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // One packet: first flag, tail over the last five steps, last flag.
  // A nonzero switch point changes the rate mid-packet.
  task automatic send_packet(int len, logic [1:0] rate, int sw, logic [1:0] rate2,
                             logic noisy);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.code_pair  = 2'($urandom());
      it.code_rate  = (sw > 0 && i >= sw) ? rate2 : rate;
      it.first_step = (i == 0);
      it.tail_step  = (i >= len - 5);
      it.last_step  = (i == len - 1);
      if (noisy && $urandom_range(0, 5) == 0) begin
        it.first_step = 1'($urandom());
        it.tail_step  = 1'($urandom());
        it.last_step  = 1'($urandom());
      end
      send_beat(it);
    end
  endtask

  initial begin
    in_item_t it;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    hold_off    = 1'b0;
    burst       = 1'b0;
    rst_ni      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: steps before any first flag, single-step packet, all codes
    it = '0;
    it.code_pair = 2'd3;
    send_beat(it);
    it.code_pair = 2'd0;
    it.last_step = 1'b1;
    send_beat(it);
    send_packet(1, 2'd0, 0, 2'd0, 1'b0);
    send_packet(6, 2'd3, 0, 2'd0, 1'b0);
    send_packet(7, 2'd1, 3, 2'd2, 1'b0);
    send_packet(8, 2'd2, 2, 2'd1, 1'b0);

    // Random packets, mostly well formed, some with scrambled flags
    for (int p = 0; p < 50; p++) begin
      if (p % 8 == 0) burst = ~burst;
      if (p == 20) hold_off = 1'b1;
      send_packet($urandom_range(2, 12), 2'($urandom()), $urandom_range(0, 6),
                  2'($urandom()), ($urandom_range(0, 3) == 0));
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/pvd_pkg.sv
rtl/core/pvd_stream_if.sv
rtl/core/pvd_front.sv
rtl/core/pvd_back.sv
rtl/core/punctured_viterbi_decoder_k7.sv
test/tb_pvd_checker.sv
test/tb_punctured_viterbi_decoder_k7.sv
